// ----- design/lmc_pkg.sv -----
// Package for the light mode controller: item, result, state and
// configuration types, register indexes and reset values.
// No dependencies; lmc_engine and the top level import it.
`default_nettype none

package lmc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CYCLE_WINDOW = 3'd0;
  localparam logic [2:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [2:0] CFG_BLINK_HALF   = 3'd2;
  localparam logic [2:0] CFG_MODULE_ON    = 3'd3;
  localparam logic [2:0] CFG_LOW_BATT     = 3'd4;
  localparam logic [2:0] CFG_DIM_DUTY     = 3'd5;
  localparam logic [2:0] CFG_ALERT_LEAD   = 3'd6;
  localparam logic [2:0] CFG_ALERT_PHASE  = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_CYCLE_WINDOW = 8'd188;
  localparam logic [7:0]  RST_DEBOUNCE     = 8'd2;
  localparam logic [7:0]  RST_BLINK_HALF   = 8'd16;
  localparam logic [11:0] RST_MODULE_ON    = 12'd1875;
  localparam logic [9:0]  RST_LOW_BATT     = 10'd740;
  localparam logic [7:0]  RST_DIM_DUTY     = 8'd150;
  localparam logic [7:0]  RST_ALERT_LEAD   = 8'd16;
  localparam logic [7:0]  RST_ALERT_PHASE  = 8'd10;

  localparam logic [7:0] FULL_DUTY        = 8'd255;
  localparam logic [2:0] ALERT_NONE       = 3'd0;
  localparam logic [2:0] ALERT_LEAD       = 3'd1;
  localparam logic [2:0] ALERT_LAST_PHASE = 3'd7;

  localparam logic [1:0] SLEEP_FULL  = 2'd0;
  localparam logic [1:0] SLEEP_TIMER = 2'd1;
  localparam logic [1:0] SLEEP_IDLE  = 2'd2;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PIN  = 2'd1,
    KIND_ADC  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ON  = 2'd1,
    MODE_DIM = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0]  cycle_window;
    logic [7:0]  debounce;
    logic [7:0]  blink_half;
    logic [11:0] module_on;
    logic [9:0]  low_batt;
    logic [7:0]  dim_duty;
    logic [7:0]  alert_lead;
    logic [7:0]  alert_phase;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       button_down;
    logic [9:0] adc_value;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic        press_pending;
    logic [7:0]  debounce_left;
    logic [7:0]  window_left;
    logic [7:0]  blink_left;
    logic        blink_enabled;
    logic        rear_out;
    logic        front_out;
    logic        module_on;
    logic [11:0] module_left;
    logic [2:0]  alert_phase;
    logic [7:0]  alert_left;
  } state_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic       front_lit;
    logic [7:0] front_duty;
    logic       rear_lit;
    logic       module_power;
    logic       adc_start;
    logic       alert_busy;
    logic [1:0] doze_level;
  } result_t;

endpackage

`default_nettype wire

// ----- design/lmc_if.sv -----
// Channel interfaces of the light mode controller: the event input
// channel and the result channel, each with valid/ready handshake.
// Depends on nothing but the field widths of the block.
`default_nettype none

interface lmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       button_down;
  logic [9:0] adc_value;

  modport source (output valid, output kind, output button_down, output adc_value,
                  input ready);
  modport sink (input valid, input kind, input button_down, input adc_value,
                output ready);
endinterface

interface lmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode_now;
  logic       front_lit;
  logic [7:0] front_duty;
  logic       rear_lit;
  logic       module_power;
  logic       adc_start;
  logic       alert_busy;
  logic [1:0] doze_level;

  modport source (output valid, output mode_now, output front_lit, output front_duty,
                  output rear_lit, output module_power, output adc_start,
                  output alert_busy, output doze_level, input ready);
  modport sink (input valid, input mode_now, input front_lit, input front_duty,
                input rear_lit, input module_power, input adc_start,
                input alert_busy, input doze_level, output ready);
endinterface

`default_nettype wire

// ----- design/lmc_engine.sv -----
// Next-state and result logic of the light mode controller for one event.
// Purely combinational; depends on lmc_pkg.
`default_nettype none

module lmc_engine
  import lmc_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  state_t     s;
  mode_t      next_mode;
  logic       adc_start;
  logic       busy;
  logic       counting;
  logic       lit_f;

  always_comb begin
    s         = state_i;
    next_mode = MODE_OFF;
    adc_start = 1'b0;

    case (item_i.kind)
      KIND_PIN: begin
        s.press_pending = 1'b1;
        s.debounce_left = cfg_i.debounce;
      end
      KIND_ADC: begin
        if (s.alert_phase == ALERT_NONE && item_i.adc_value <= cfg_i.low_batt) begin
          s.alert_phase = ALERT_LEAD;
          s.alert_left  = cfg_i.alert_lead;
        end
      end
      KIND_TICK: begin
        if (s.window_left != 8'd0)   s.window_left   = s.window_left - 8'd1;
        if (s.debounce_left != 8'd0) s.debounce_left = s.debounce_left - 8'd1;
        if (s.blink_left != 8'd0)    s.blink_left    = s.blink_left - 8'd1;
        if (s.module_on && s.module_left != 12'd0) begin
          s.module_left = s.module_left - 12'd1;
        end

        if (s.alert_phase != ALERT_NONE) begin
          if (s.alert_left != 8'd0) s.alert_left = s.alert_left - 8'd1;
          if (s.alert_left == 8'd0) begin
            if (s.alert_phase == ALERT_LAST_PHASE) begin
              s.alert_phase   = ALERT_NONE;
              s.front_out     = 1'b0;
              s.rear_out      = 1'b0;
              s.blink_enabled = 1'b0;
            end else begin
              s.alert_phase = s.alert_phase + 3'd1;
              s.alert_left  = cfg_i.alert_phase;
            end
          end
        end else if (s.press_pending && s.debounce_left == 8'd0) begin
          s.press_pending = 1'b0;
          if (item_i.button_down) begin
            // A lit light with an expired window turns off; otherwise cycle.
            if (state_i.mode != MODE_OFF && s.window_left == 8'd0) begin
              next_mode = MODE_OFF;
            end else if (state_i.mode == MODE_ON) begin
              next_mode = MODE_DIM;
            end else begin
              next_mode = MODE_ON;
            end
            s.module_on   = 1'b1;
            s.module_left = cfg_i.module_on;
            s.mode        = next_mode;
            s.window_left = cfg_i.cycle_window;
            if (next_mode == MODE_OFF) begin
              s.front_out     = 1'b0;
              s.rear_out      = 1'b0;
              s.blink_enabled = 1'b0;
              adc_start       = 1'b1;
            end else begin
              s.front_out     = 1'b1;
              s.rear_out      = 1'b1;
              s.blink_enabled = 1'b1;
              s.blink_left    = cfg_i.blink_half;
            end
          end
        end else begin
          if (s.blink_enabled && s.blink_left == 8'd0) begin
            s.rear_out   = ~s.rear_out;
            s.blink_left = cfg_i.blink_half;
          end
          if (s.module_on && s.module_left == 12'd0) s.module_on = 1'b0;
        end
      end
      default: begin
        // The unused event code leaves the state alone.
      end
    endcase
  end

  always_comb begin
    busy     = (s.alert_phase != ALERT_NONE);
    lit_f    = busy ? ~s.alert_phase[0] : s.front_out;
    counting = (s.debounce_left != 8'd0) || (s.window_left != 8'd0) ||
               (s.blink_left != 8'd0) || (s.module_on && s.module_left != 12'd0) ||
               busy;

    result_o.mode_now     = s.mode;
    result_o.front_lit    = lit_f;
    result_o.rear_lit     = busy ? ~s.alert_phase[0] : s.rear_out;
    result_o.module_power = s.module_on;
    result_o.adc_start    = adc_start;
    result_o.alert_busy   = busy;

    if (!lit_f) begin
      result_o.front_duty = 8'd0;
    end else if (!busy && s.mode == MODE_DIM) begin
      result_o.front_duty = cfg_i.dim_duty;
    end else begin
      result_o.front_duty = FULL_DUTY;
    end

    if (!busy && s.front_out && s.mode == MODE_DIM) begin
      result_o.doze_level = SLEEP_IDLE;
    end else if (counting) begin
      result_o.doze_level = SLEEP_TIMER;
    end else begin
      result_o.doze_level = SLEEP_FULL;
    end
  end

  assign state_o = s;

endmodule

`default_nettype wire

// ----- design/light_mode_controller_unit.sv -----
// Top level of the one-button light controller: configuration registers,
// controller state, result register and channel handshakes.
// Depends on lmc_pkg, lmc_in_if, lmc_out_if and lmc_engine.
`default_nettype none

// The controller takes one event transaction per clock cycle: a timer tick,
// a button pin change or a battery ADC result. Each event updates the
// controller state in the cycle it is accepted, and the matching result
// transaction (mode, front and rear light drive, front PWM duty, battery
// module supply, ADC start pulse, alert flag and allowed sleep level) is
// presented from the result register on the next cycle. The rate is one
// event per cycle, set by the single state update between the input
// handshake and the result register; in_chan.ready drops only while the
// result register holds a result that the sink does not take in that cycle.
// A pin change arms a press that is confirmed by the button level on the
// first tick on which the debounce count, counted down, is zero. A confirmed press turns
// a lit light off once the cycle window has expired and otherwise steps
// OFF to ON, ON to DIMMED and DIMMED to ON; turning off requests a battery
// measurement through adc_start. An ADC value at or below the low battery
// threshold starts an alert made of a dark lead and three flashes of both
// lights, timed in ticks; presses, rear blinking and the module timeout
// wait until the alert is over, and both lights are left off after it.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at
// once and are meant to be issued while no event is in flight.

module light_mode_controller_unit
  import lmc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  lmc_in_if.sink                       in_chan,
  lmc_out_if.source                    out_chan,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t result_r;
  result_t result_nxt;
  item_t   item;
  logic    out_valid_r;
  logic    in_accept;

  // The result register frees up in the same cycle it is drained.
  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign in_accept     = in_chan.valid & in_chan.ready;

  assign item = {in_chan.kind, in_chan.button_down, in_chan.adc_value};

  // Configuration registers; each takes the low bits of the write data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cycle_window <= RST_CYCLE_WINDOW;
      cfg_r.debounce     <= RST_DEBOUNCE;
      cfg_r.blink_half   <= RST_BLINK_HALF;
      cfg_r.module_on    <= RST_MODULE_ON;
      cfg_r.low_batt     <= RST_LOW_BATT;
      cfg_r.dim_duty     <= RST_DIM_DUTY;
      cfg_r.alert_lead   <= RST_ALERT_LEAD;
      cfg_r.alert_phase  <= RST_ALERT_PHASE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CYCLE_WINDOW: cfg_r.cycle_window <= cfg_data[7:0];
        CFG_DEBOUNCE:     cfg_r.debounce     <= cfg_data[7:0];
        CFG_BLINK_HALF:   cfg_r.blink_half   <= cfg_data[7:0];
        CFG_MODULE_ON:    cfg_r.module_on    <= cfg_data[11:0];
        CFG_LOW_BATT:     cfg_r.low_batt     <= cfg_data[9:0];
        CFG_DIM_DUTY:     cfg_r.dim_duty     <= cfg_data[7:0];
        CFG_ALERT_LEAD:   cfg_r.alert_lead   <= cfg_data[7:0];
        CFG_ALERT_PHASE:  cfg_r.alert_phase  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  lmc_engine u_engine (
    .cfg_i    (cfg_r),
    .state_i  (state_r),
    .item_i   (item),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  // Controller state advances once per accepted event.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode          <= MODE_OFF;
      state_r.press_pending <= 1'b0;
      state_r.debounce_left <= 8'd0;
      state_r.window_left   <= 8'd0;
      state_r.blink_left    <= 8'd0;
      state_r.blink_enabled <= 1'b0;
      state_r.rear_out      <= 1'b0;
      state_r.front_out     <= 1'b0;
      state_r.module_on     <= 1'b0;
      state_r.module_left   <= 12'd0;
      state_r.alert_phase   <= ALERT_NONE;
      state_r.alert_left    <= 8'd0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  // The payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.mode_now     = result_r.mode_now;
  assign out_chan.front_lit    = result_r.front_lit;
  assign out_chan.front_duty   = result_r.front_duty;
  assign out_chan.rear_lit     = result_r.rear_lit;
  assign out_chan.module_power = result_r.module_power;
  assign out_chan.adc_start    = result_r.adc_start;
  assign out_chan.alert_busy   = result_r.alert_busy;
  assign out_chan.doze_level   = result_r.doze_level;

endmodule

`default_nettype wire

// ----- sim/lamp_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the light mode controller: follows register writes, predicts
// the result of every accepted event and compares it with the result channel.
// Depends on lmc_pkg and the channel interfaces in lmc_if.sv.

module lamp_result_checker
  import lmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  lmc_in_if                      ev_ch,
  lmc_out_if                     res_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     results_due
);

  typedef struct packed {
    logic [7:0]  window;
    logic [7:0]  debounce;
    logic [7:0]  blink;
    logic [11:0] module_ticks;
    logic [9:0]  low_batt;
    logic [7:0]  dim_duty;
    logic [7:0]  lead;
    logic [7:0]  phase_len;
  } lamp_settings_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        press_armed;
    logic [7:0]  debounce_left;
    logic [7:0]  window_left;
    logic [7:0]  blink_left;
    logic        blinking;
    logic        rear_on;
    logic        front_on;
    logic        module_on;
    logic [11:0] module_left;
    logic [2:0]  alert_phase;
    logic [7:0]  alert_left;
  } lamp_state_t;

  lamp_settings_t regs;
  lamp_state_t    st;
  result_t        due_q[$];
  int             fails = 0;

  // Applies one event to the lamp state and returns the result it reports.
  function automatic result_t advance_lamp(input item_t ev);
    result_t    r;
    logic       turned_off;
    logic       busy;
    logic       lit;
    logic       counting;
    logic [1:0] next_mode;
    turned_off = 1'b0;
    case (ev.kind)
      KIND_PIN: begin
        st.press_armed   = 1'b1;
        st.debounce_left = regs.debounce;
      end
      KIND_ADC: begin
        if (st.alert_phase == ALERT_NONE && ev.adc_value <= regs.low_batt) begin
          st.alert_phase = ALERT_LEAD;
          st.alert_left  = regs.lead;
        end
      end
      KIND_TICK: begin
        if (st.window_left != 0) st.window_left = st.window_left - 8'd1;
        if (st.debounce_left != 0) st.debounce_left = st.debounce_left - 8'd1;
        if (st.blink_left != 0) st.blink_left = st.blink_left - 8'd1;
        if (st.module_on && st.module_left != 0) st.module_left = st.module_left - 12'd1;
        if (st.alert_phase != ALERT_NONE) begin
          if (st.alert_left != 0) st.alert_left = st.alert_left - 8'd1;
          if (st.alert_left == 0) begin
            if (st.alert_phase >= ALERT_LAST_PHASE) begin
              st.alert_phase = ALERT_NONE;
              st.front_on    = 1'b0;
              st.rear_on     = 1'b0;
              st.blinking    = 1'b0;
            end else begin
              st.alert_phase = st.alert_phase + 3'd1;
              st.alert_left  = regs.phase_len;
            end
          end
        end else if (st.press_armed && st.debounce_left == 0) begin
          st.press_armed = 1'b0;
          if (ev.button_down) begin
            if (st.mode != MODE_OFF && st.window_left == 0) next_mode = MODE_OFF;
            else if (st.mode == MODE_ON) next_mode = MODE_DIM;
            else next_mode = MODE_ON;
            st.module_on   = 1'b1;
            st.module_left = regs.module_ticks;
            st.mode        = next_mode;
            st.window_left = regs.window;
            if (next_mode == MODE_ON || next_mode == MODE_DIM) begin
              st.front_on   = 1'b1;
              st.rear_on    = 1'b1;
              st.blinking   = 1'b1;
              st.blink_left = regs.blink;
            end else begin
              st.front_on = 1'b0;
              st.rear_on  = 1'b0;
              st.blinking = 1'b0;
            end
            turned_off = (next_mode == MODE_OFF);
          end
        end else begin
          if (st.blinking && st.blink_left == 0) begin
            st.rear_on    = !st.rear_on;
            st.blink_left = regs.blink;
          end
          if (st.module_on && st.module_left == 0) st.module_on = 1'b0;
        end
      end
      default: ;
    endcase

    busy = (st.alert_phase != ALERT_NONE);
    if (busy) begin
      lit          = !st.alert_phase[0];
      r.front_lit  = lit;
      r.rear_lit   = lit;
      r.front_duty = lit ? FULL_DUTY : 8'd0;
    end else begin
      r.front_lit  = st.front_on;
      r.rear_lit   = st.rear_on;
      r.front_duty = !st.front_on ? 8'd0 : (st.mode == MODE_DIM ? regs.dim_duty : FULL_DUTY);
    end
    counting = st.debounce_left != 0 || st.window_left != 0 || st.blink_left != 0 ||
               (st.module_on && st.module_left != 0) || busy;
    if (!busy && st.front_on && st.mode == MODE_DIM) r.doze_level = SLEEP_IDLE;
    else r.doze_level = counting ? SLEEP_TIMER : SLEEP_FULL;
    r.mode_now     = st.mode;
    r.module_power = st.module_on;
    r.adc_start    = turned_off;
    r.alert_busy   = busy;
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf({"mode=%0d front=%0b duty=%0d rear=%0b module=%0b",
                      " adc_start=%0b alert=%0b doze=%0d"},
                     r.mode_now, r.front_lit, r.front_duty, r.rear_lit, r.module_power,
                     r.adc_start, r.alert_busy, r.doze_level);
  endfunction

  always @(posedge clk) begin
    item_t   ev;
    result_t got;
    result_t want;
    if (!rst_n) begin
      regs.window       = RST_CYCLE_WINDOW;
      regs.debounce     = RST_DEBOUNCE;
      regs.blink        = RST_BLINK_HALF;
      regs.module_ticks = RST_MODULE_ON;
      regs.low_batt     = RST_LOW_BATT;
      regs.dim_duty     = RST_DIM_DUTY;
      regs.lead         = RST_ALERT_LEAD;
      regs.phase_len    = RST_ALERT_PHASE;
      st = '0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CYCLE_WINDOW: regs.window       = cfg_data[7:0];
          CFG_DEBOUNCE:     regs.debounce     = cfg_data[7:0];
          CFG_BLINK_HALF:   regs.blink        = cfg_data[7:0];
          CFG_MODULE_ON:    regs.module_ticks = cfg_data[11:0];
          CFG_LOW_BATT:     regs.low_batt     = cfg_data[9:0];
          CFG_DIM_DUTY:     regs.dim_duty     = cfg_data[7:0];
          CFG_ALERT_LEAD:   regs.lead         = cfg_data[7:0];
          CFG_ALERT_PHASE:  regs.phase_len    = cfg_data[7:0];
          default: ;
        endcase
      end
      // The event is taken first so that a block with no output register
      // would still be matched against the right expectation.
      if (ev_ch.valid && ev_ch.ready) begin
        ev.kind        = ev_ch.kind;
        ev.button_down = ev_ch.button_down;
        ev.adc_value   = ev_ch.adc_value;
        due_q.push_back(advance_lamp(ev));
      end
      if (res_ch.valid && res_ch.ready) begin
        got.mode_now     = res_ch.mode_now;
        got.front_lit    = res_ch.front_lit;
        got.front_duty   = res_ch.front_duty;
        got.rear_lit     = res_ch.rear_lit;
        got.module_power = res_ch.module_power;
        got.adc_start    = res_ch.adc_start;
        got.alert_busy   = res_ch.alert_busy;
        got.doze_level   = res_ch.doze_level;
        if (due_q.size() == 0) begin
          fails++;
          $display("%0t: result with no event waiting: expected none, actual %s",
                   $time, show_result(got));
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: result mismatch: expected %s", $time, show_result(want));
            $display("%0t:                  actual   %s", $time, show_result(got));
          end
        end
      end
    end
    mismatch_count <= fails;
    results_due    <= due_q.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Top of the light mode controller testbench: clock, reset, register writes,
// event stimulus, result channel back-pressure and the final verdict.
// Depends on lmc_pkg, lmc_if.sv, the block itself and lamp_result_checker.

module tb;
  import lmc_pkg::*;

  // Kind code that the block has no use for; it must only report the state.
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int ITEMS_PER_SETTING = 150;
  localparam int HOLD_CYCLES = 64;

  // Register settings that the run steps through, between phases.
  typedef enum {SET_SMALL, SET_ZERO, SET_MAX, SET_RANDOM, SET_DEFAULT} setting_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Written only by the stimulus process, with nonblocking assignments, so
  // that the receiver process sees each change at a clock edge.
  logic calm = 1'b0;
  int   hold_ticket = 0;

  int   sent = 0;
  int   mismatch_count;
  int   results_due;

  // Register values currently programmed, used to shape the stimulus.
  logic [CFG_DATA_W-1:0] reg_now [8];

  lmc_in_if  ev_if ();
  lmc_out_if res_if ();

  light_mode_controller_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (ev_if),
    .out_chan  (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lamp_result_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .ev_ch          (ev_if),
    .res_ch         (res_if),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one event and returns at the edge where the transaction is taken.
  // Valid stays high on return, so back-to-back events keep it high without a
  // drop; the sender idles at random unless the calm stretch is active.
  task automatic send_item(input logic [1:0] kind, input logic btn, input logic [9:0] adc);
    while (!calm && $urandom_range(99) < 14) begin
      ev_if.valid <= 1'b0;
      @(posedge clk);
    end
    ev_if.valid       <= 1'b1;
    ev_if.kind        <= kind;
    ev_if.button_down <= btn;
    ev_if.adc_value   <= adc;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    if (kind != KIND_SPARE) sent++;
  endtask

  // Stops offering events and waits until every predicted result has come.
  // The checker's count is registered, hence the first wait.
  task automatic wait_drained();
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Result channel sink. It stalls in about one cycle out of seven, never
  // during the calm stretch, and holds ready low for a long stretch each time
  // the stimulus bumps the hold ticket; the count runs in this process alone.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  initial begin : stimulus
    setting_t              plan [8];
    logic [CFG_DATA_W-1:0] word;
    logic [9:0]            adc;
    int                    thr;
    int                    deb;
    int                    n;
    int                    pick;
    logic                  paused;

    plan = '{SET_SMALL, SET_ZERO, SET_SMALL, SET_MAX, SET_SMALL, SET_RANDOM,
             SET_DEFAULT, SET_SMALL};
    paused = 1'b0;
    ev_if.valid       <= 1'b0;
    ev_if.kind        <= KIND_TICK;
    ev_if.button_down <= 1'b0;
    ev_if.adc_value   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events under the reset register values, where the debounce
    // takes two ticks. The unused kind only reports the state.
    send_item(KIND_SPARE, 1'b1, 10'd1023);
    send_item(KIND_TICK, 1'b0, 10'd0);
    // Three confirmed presses inside the cycle window: OFF to ON, ON to
    // DIMMED and DIMMED back to ON.
    repeat (3) begin
      send_item(KIND_PIN, 1'b0, 10'd512);
      send_item(KIND_TICK, 1'b0, 10'd0);
      send_item(KIND_TICK, 1'b1, 10'd1023);
    end
    // A pin change whose button is up again after the debounce is no press.
    send_item(KIND_PIN, 1'b1, 10'd0);
    send_item(KIND_TICK, 1'b1, 10'd0);
    send_item(KIND_TICK, 1'b0, 10'd0);
    // Battery readings: full scale and one above the threshold are fine, the
    // threshold itself starts the alert, and a reading during it is ignored.
    send_item(KIND_ADC, 1'b0, 10'd1023);
    send_item(KIND_ADC, 1'b1, RST_LOW_BATT + 10'd1);
    send_item(KIND_ADC, 1'b0, RST_LOW_BATT);
    send_item(KIND_ADC, 1'b0, 10'd0);
    // A click during the alert stays pending until the alert is over.
    send_item(KIND_PIN, 1'b1, 10'd1023);
    send_item(KIND_TICK, 1'b1, 10'd0);
    send_item(KIND_TICK, 1'b1, 10'd0);
    send_item(KIND_SPARE, 1'b0, 10'd0);

    foreach (plan[p]) begin
      // Registers change only while nothing is in flight. The block answers
      // every event, so an empty expectation queue plus a wait for the result
      // register is enough.
      wait_drained();
      repeat (2) @(posedge clk);

      case (plan[p])
        SET_SMALL: begin
          // Short timings so that windows, blinks, timeouts and whole alerts
          // run out many times within one phase.
          reg_now[CFG_CYCLE_WINDOW] = CFG_DATA_W'($urandom_range(12, 1));
          reg_now[CFG_DEBOUNCE]     = CFG_DATA_W'($urandom_range(4, 0));
          reg_now[CFG_BLINK_HALF]   = CFG_DATA_W'($urandom_range(5, 1));
          reg_now[CFG_MODULE_ON]    = CFG_DATA_W'($urandom_range(30, 1));
          reg_now[CFG_LOW_BATT]     = CFG_DATA_W'($urandom_range(1023, 0));
          reg_now[CFG_DIM_DUTY]     = CFG_DATA_W'($urandom_range(255, 0));
          reg_now[CFG_ALERT_LEAD]   = CFG_DATA_W'($urandom_range(6, 1));
          reg_now[CFG_ALERT_PHASE]  = CFG_DATA_W'($urandom_range(6, 1));
        end
        SET_ZERO: begin
          // Zero timings end each alert phase on the next tick and toggle the
          // rear light on every tick; only a reading of zero is low.
          foreach (reg_now[i]) reg_now[i] = '0;
        end
        SET_MAX: begin
          reg_now[CFG_CYCLE_WINDOW] = 12'd255;
          reg_now[CFG_DEBOUNCE]     = 12'd255;
          reg_now[CFG_BLINK_HALF]   = 12'd255;
          reg_now[CFG_MODULE_ON]    = 12'd4095;
          reg_now[CFG_LOW_BATT]     = 12'd1023;
          reg_now[CFG_DIM_DUTY]     = 12'd255;
          reg_now[CFG_ALERT_LEAD]   = 12'd255;
          reg_now[CFG_ALERT_PHASE]  = 12'd255;
        end
        SET_RANDOM: begin
          reg_now[CFG_CYCLE_WINDOW] = CFG_DATA_W'($urandom_range(255, 1));
          reg_now[CFG_DEBOUNCE]     = CFG_DATA_W'($urandom_range(20, 0));
          reg_now[CFG_BLINK_HALF]   = CFG_DATA_W'($urandom_range(255, 1));
          reg_now[CFG_MODULE_ON]    = CFG_DATA_W'($urandom_range(4095, 1));
          reg_now[CFG_LOW_BATT]     = CFG_DATA_W'($urandom_range(1023, 0));
          reg_now[CFG_DIM_DUTY]     = CFG_DATA_W'($urandom_range(255, 0));
          reg_now[CFG_ALERT_LEAD]   = CFG_DATA_W'($urandom_range(40, 1));
          reg_now[CFG_ALERT_PHASE]  = CFG_DATA_W'($urandom_range(40, 1));
        end
        default: begin
          reg_now[CFG_CYCLE_WINDOW] = CFG_DATA_W'(RST_CYCLE_WINDOW);
          reg_now[CFG_DEBOUNCE]     = CFG_DATA_W'(RST_DEBOUNCE);
          reg_now[CFG_BLINK_HALF]   = CFG_DATA_W'(RST_BLINK_HALF);
          reg_now[CFG_MODULE_ON]    = RST_MODULE_ON;
          reg_now[CFG_LOW_BATT]     = CFG_DATA_W'(RST_LOW_BATT);
          reg_now[CFG_DIM_DUTY]     = CFG_DATA_W'(RST_DIM_DUTY);
          reg_now[CFG_ALERT_LEAD]   = CFG_DATA_W'(RST_ALERT_LEAD);
          reg_now[CFG_ALERT_PHASE]  = CFG_DATA_W'(RST_ALERT_PHASE);
        end
      endcase

      // All eight registers are written on consecutive edges. The data bits
      // above a narrow register are filled with noise that it must drop.
      for (int i = 0; i < 8; i++) begin
        if (i == CFG_MODULE_ON) word = reg_now[i];
        else if (i == CFG_LOW_BATT) word = {2'($urandom), reg_now[i][9:0]};
        else word = {4'($urandom), reg_now[i][7:0]};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INDEX_W'(i);
        cfg_data  <= word;
        @(posedge clk);
      end
      cfg_we <= 1'b0;

      thr = int'(reg_now[CFG_LOW_BATT]);
      deb = int'(reg_now[CFG_DEBOUNCE]);
      sent = 0;
      // The third phase opens with the sink holding off while events keep
      // coming, so the block fills up and stalls its input. The fifth phase
      // runs without any idling on either side.
      if (p == 2) hold_ticket <= hold_ticket + 1;
      calm <= (p == 4);

      while (sent < ITEMS_PER_SETTING) begin
        // Once in the run, the sender stops mid-phase until all results are in.
        if (p == 5 && sent >= 75 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
          // A press: up to two bounces, one more pin change, then ticks until the
          // debounce has run out; the last tick usually sees the button down.
          repeat ($urandom_range(2)) begin
            send_item(KIND_PIN, 1'($urandom), 10'($urandom));
            if ($urandom_range(1) == 1) send_item(KIND_TICK, 1'($urandom), 10'($urandom));
          end
          send_item(KIND_PIN, 1'($urandom), 10'($urandom));
          n = (deb == 0) ? 1 : deb;
          for (int t = 1; t <= n; t++)
            send_item(KIND_TICK, (t == n) ? ($urandom_range(9) != 0) : 1'($urandom),
                      10'($urandom));
        end else if (pick < 72) begin
          // A run of ticks lets windows, blinks, timeouts and alerts expire.
          repeat ($urandom_range(24, 1)) send_item(KIND_TICK, 1'($urandom), 10'($urandom));
        end else if (pick < 86) begin
          // A battery reading: zero, full scale, the threshold, one above it or random.
          case ($urandom_range(4))
            0: adc = 10'd0;
            1: adc = 10'd1023;
            2: adc = 10'(thr);
            3: adc = (thr == 1023) ? 10'(thr) : 10'(thr + 1);
            default: adc = 10'($urandom_range(1023));
          endcase
          send_item(KIND_ADC, 1'($urandom), adc);
        end else begin
          // Noise: any kind, now and then the unused one, with random fields.
          send_item(($urandom_range(19) == 0) ? KIND_SPARE : 2'($urandom_range(2)),
                    1'($urandom), 10'($urandom));
        end
      end
      calm <= 1'b0;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including the long maximum settings.
  initial begin : watchdog
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
